>>> src/eps_pkg.sv
// Package for the EMA priority scheduler: default sizes, codes, constants and the
// controller state type. Used by ema_priority_scheduler.
package eps_pkg;

    localparam int MAX_PROCS_DEF     = 64;
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int SAMPLE_BITS_DEF   = 24;

    localparam logic [6:0]  ALPHA_RST = 7'd30;
    localparam logic [23:0] BUSY_RST  = 24'd80;
    localparam logic [23:0] IDLE_RST  = 24'd10;
    localparam logic [6:0]  PCT_FULL  = 7'd100;

    localparam logic [6:0] PRIO_HIGH = 7'd90;
    localparam logic [6:0] PRIO_LOW  = 7'd20;
    localparam logic [6:0] PRIO_MID  = 7'd50;

    // Division by 100 as a multiply by ceil(2^38 / 100) and a shift by 38.
    localparam logic [31:0] RECIP_100 = 32'd2748779070;
    localparam int          RECIP_SHIFT = 38;

    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_UPDATE   = 2'd1;
    localparam logic [1:0] REQ_PICK     = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_BUSY  = 2'd1;
    localparam logic [1:0] CFG_IDLE  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REG_CLR,
        S_SCAN,
        S_WIN_WR,
        S_FOLD_RD,
        S_FOLD_MUL,
        S_FOLD_DIV,
        S_PRIO,
        S_RESP
    } t_state;

endpackage

>>> src/eps_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module eps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ema_priority_scheduler.sv
// Top level of the EMA priority scheduler: controller, entry table and sample windows.
// Depends on eps_pkg and eps_ram.
//
// Channel   Direction  Handshake                  Payload
// s         in         i_s_tvalid / o_s_tready    tuser: req_type; tdata: proc_id, cpu, mem
// m         out        o_m_tvalid / i_m_tready    tuser: status; tdata: id, cpu, mem, prio
// cfg       in         i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// One word is worked on at a time. Register clears the new entry's sample window.
// Update runs a table scan, then a window write, an EMA fold through the window RAM,
// a priority write and the response; pick runs a table scan and the response.
// Reset leaves the table empty; RAM contents need no clearing.
// A stalled result is held in the output register while the next word is taken.
module ema_priority_scheduler #(
    parameter int MAX_PROCS     = eps_pkg::MAX_PROCS_DEF,
    parameter int HISTORY_DEPTH = eps_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_BITS   = eps_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // proc_id[31:0], cpu_usage[55:32], mem_usage[79:56]
    input  logic [1:0]  i_s_tuser,   // req_type[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // chosen_id[31:0], cpu_estimate[55:32],
                                     // mem_estimate[79:56], priority_res[86:80]
    output logic [1:0]  o_m_tuser,   // status[1:0]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata
);

    localparam int IW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW    = $clog2(MAX_PROCS + 1);
    localparam int SW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int WD    = MAX_PROCS * HISTORY_DEPTH;
    localparam int WAW   = (WD > 1) ? $clog2(WD) : 1;
    localparam int EW    = 32 + SW + 7;
    localparam int SB    = SAMPLE_BITS;
    localparam int SUMW  = SB + 7;
    localparam int PRODW = SUMW + 32;
    localparam logic [CW-1:0]  COUNT_MAX = CW'(MAX_PROCS);
    localparam logic [SW-1:0]  KLAST     = SW'(HISTORY_DEPTH - 1);
    localparam logic [WAW-1:0] HW        = WAW'(HISTORY_DEPTH);

    eps_pkg::t_state r_state, n_state;
    logic [6:0]   r_alpha, n_alpha;
    logic [23:0]  r_busy, n_busy, r_idle, n_idle;
    logic [1:0]   r_req, n_req;
    logic [31:0]  r_id, n_id;
    logic [SB-1:0] r_cpu, n_cpu, r_mem, n_mem;
    logic [CW-1:0] r_count, n_count, r_idx, n_idx;
    logic         r_pend, n_pend;
    logic [IW-1:0] r_pidx, n_pidx, r_hit, n_hit;
    logic [6:0]   r_best, n_best;
    logic [31:0]  r_best_id, n_best_id;
    logic [SW-1:0] r_slot, n_slot, r_k, n_k;
    logic [SB-1:0] r_acc_c, n_acc_c, r_acc_m, n_acc_m;
    logic [SUMW-1:0] r_sum_c, n_sum_c, r_sum_m, n_sum_m;
    logic [1:0]   r_st, n_st;
    logic [31:0]  r_cid, n_cid;
    logic [6:0]   r_pr, n_pr;
    logic         r_ovalid, n_ovalid;
    logic [87:0]  r_odata, n_odata;
    logic [1:0]   r_ouser, n_ouser;

    logic          accept;
    logic [6:0]    alpha_c, alpha_inv;
    logic          e_we;
    logic [IW-1:0] e_waddr;
    logic [EW-1:0] e_wdata, e_rdata;
    logic          w_we;
    logic [WAW-1:0] w_waddr, w_raddr;
    logic [2*SB-1:0] w_wdata, w_rdata;
    logic [31:0]   e_id;
    logic [SW-1:0] e_slot;
    logic [6:0]    e_prio;
    logic [SB-1:0] w_c, w_m;
    logic [PRODW-1:0] prod_c, prod_m;
    logic [6:0]    new_prio;
    logic          hit, issue;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == eps_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    assign alpha_c   = (r_alpha > eps_pkg::PCT_FULL) ? eps_pkg::PCT_FULL : r_alpha;
    assign alpha_inv = eps_pkg::PCT_FULL - alpha_c;

    assign e_id   = e_rdata[EW-1 -: 32];
    assign e_slot = e_rdata[7 +: SW];
    assign e_prio = e_rdata[6:0];
    assign w_c    = w_rdata[SB-1:0];
    assign w_m    = w_rdata[2*SB-1:SB];

    assign prod_c = PRODW'(r_sum_c) * PRODW'(eps_pkg::RECIP_100);
    assign prod_m = PRODW'(r_sum_m) * PRODW'(eps_pkg::RECIP_100);

    assign w_raddr = WAW'(r_hit) * HW + WAW'(r_k);

    assign hit   = r_pend && (r_req == eps_pkg::REQ_UPDATE) && (e_id == r_id);
    assign issue = !hit && (r_idx < r_count);

    always_comb begin
        if (24'(r_acc_c) > r_busy) begin
            new_prio = eps_pkg::PRIO_HIGH;
        end else if (24'(r_acc_c) < r_idle) begin
            new_prio = eps_pkg::PRIO_LOW;
        end else begin
            new_prio = eps_pkg::PRIO_MID;
        end
    end

    always_comb begin
        n_state = r_state;
        n_alpha = r_alpha;
        n_busy = r_busy;
        n_idle = r_idle;
        n_req = r_req;
        n_id = r_id;
        n_cpu = r_cpu;
        n_mem = r_mem;
        n_count = r_count;
        n_idx = r_idx;
        n_pend = r_pend;
        n_pidx = r_pidx;
        n_hit = r_hit;
        n_best = r_best;
        n_best_id = r_best_id;
        n_slot = r_slot;
        n_k = r_k;
        n_acc_c = r_acc_c;
        n_acc_m = r_acc_m;
        n_sum_c = r_sum_c;
        n_sum_m = r_sum_m;
        n_st = r_st;
        n_cid = r_cid;
        n_pr = r_pr;
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata = r_odata;
        n_ouser = r_ouser;
        e_we = 1'b0;
        e_waddr = r_hit;
        e_wdata = {r_id, r_slot, new_prio};
        w_we = 1'b0;
        w_waddr = WAW'(r_hit) * HW + WAW'(r_slot);
        w_wdata = {r_mem, r_cpu};

        if (i_cfg_we) begin
            case (i_cfg_addr)
                eps_pkg::CFG_ALPHA: n_alpha = i_cfg_wdata[6:0];
                eps_pkg::CFG_BUSY:  n_busy = i_cfg_wdata;
                eps_pkg::CFG_IDLE:  n_idle = i_cfg_wdata;
                default: ;
            endcase
        end

        case (r_state)
            eps_pkg::S_IDLE: begin
                if (accept) begin
                    n_req = i_s_tuser;
                    n_id = i_s_tdata[31:0];
                    n_cpu = i_s_tdata[32 +: SB];
                    n_mem = i_s_tdata[56 +: SB];
                    n_idx = '0;
                    n_pend = 1'b0;
                    n_best = '0;
                    n_best_id = '0;
                    n_k = '0;
                    n_st = eps_pkg::ST_OK;
                    n_cid = '0;
                    n_pr = '0;
                    n_acc_c = '0;
                    n_acc_m = '0;
                    case (i_s_tuser)
                        eps_pkg::REQ_REGISTER: begin
                            if (r_count >= COUNT_MAX) begin
                                n_st = eps_pkg::ST_FULL;
                                n_state = eps_pkg::S_RESP;
                            end else begin
                                e_we = 1'b1;
                                e_waddr = r_count[IW-1:0];
                                e_wdata = {i_s_tdata[31:0], {SW{1'b0}}, eps_pkg::PRIO_MID};
                                n_state = eps_pkg::S_REG_CLR;
                            end
                        end
                        eps_pkg::REQ_UPDATE, eps_pkg::REQ_PICK: n_state = eps_pkg::S_SCAN;
                        default: n_state = eps_pkg::S_RESP;
                    endcase
                end
            end
            eps_pkg::S_REG_CLR: begin
                w_we = 1'b1;
                w_waddr = WAW'(r_count[IW-1:0]) * HW + WAW'(r_k);
                w_wdata = '0;
                n_k = r_k + 1'b1;
                if (r_k == KLAST) begin
                    n_count = r_count + 1'b1;
                    n_state = eps_pkg::S_RESP;
                end
            end
            eps_pkg::S_SCAN: begin
                if (r_pend && (r_req == eps_pkg::REQ_PICK) && (e_prio > r_best)) begin
                    n_best = e_prio;
                    n_best_id = e_id;
                end
                n_pend = issue;
                n_pidx = r_idx[IW-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (hit) begin
                    n_hit = r_pidx;
                    n_slot = e_slot;
                    n_state = eps_pkg::S_WIN_WR;
                end else if (!issue) begin
                    n_state = eps_pkg::S_RESP;
                    if (r_req == eps_pkg::REQ_UPDATE) begin
                        n_st = eps_pkg::ST_UNKNOWN;
                    end else begin
                        n_st = (r_count == '0) ? eps_pkg::ST_EMPTY : eps_pkg::ST_OK;
                        n_cid = n_best_id;
                        n_pr = n_best;
                    end
                end
            end
            eps_pkg::S_WIN_WR: begin
                w_we = 1'b1;
                n_k = '0;
                n_state = eps_pkg::S_FOLD_RD;
            end
            eps_pkg::S_FOLD_RD: begin
                n_state = eps_pkg::S_FOLD_MUL;
            end
            eps_pkg::S_FOLD_MUL: begin
                if (r_k == '0) begin
                    n_acc_c = w_c;
                    n_acc_m = w_m;
                    if (r_k == KLAST) begin
                        n_state = eps_pkg::S_PRIO;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = eps_pkg::S_FOLD_RD;
                    end
                end else begin
                    n_sum_c = SUMW'(alpha_c) * SUMW'(w_c) + SUMW'(alpha_inv) * SUMW'(r_acc_c);
                    n_sum_m = SUMW'(alpha_c) * SUMW'(w_m) + SUMW'(alpha_inv) * SUMW'(r_acc_m);
                    n_state = eps_pkg::S_FOLD_DIV;
                end
            end
            eps_pkg::S_FOLD_DIV: begin
                n_acc_c = prod_c[eps_pkg::RECIP_SHIFT +: SB];
                n_acc_m = prod_m[eps_pkg::RECIP_SHIFT +: SB];
                if (r_k == KLAST) begin
                    n_state = eps_pkg::S_PRIO;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = eps_pkg::S_FOLD_RD;
                end
            end
            eps_pkg::S_PRIO: begin
                e_we = 1'b1;
                e_wdata = {r_id, (r_slot == KLAST) ? SW'(0) : SW'(r_slot + 1'b1), new_prio};
                n_pr = new_prio;
                n_st = eps_pkg::ST_OK;
                n_state = eps_pkg::S_RESP;
            end
            eps_pkg::S_RESP: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ouser = r_st;
                    n_odata = {1'b0, r_pr, 24'(r_acc_m), 24'(r_acc_c), r_cid};
                    n_state = eps_pkg::S_IDLE;
                end
            end
            default: n_state = eps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eps_pkg::S_IDLE;
            r_alpha <= eps_pkg::ALPHA_RST;
            r_busy <= eps_pkg::BUSY_RST;
            r_idle <= eps_pkg::IDLE_RST;
            r_count <= '0;
            r_pend <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_alpha <= n_alpha;
            r_busy <= n_busy;
            r_idle <= n_idle;
            r_count <= n_count;
            r_pend <= n_pend;
            r_ovalid <= n_ovalid;
        end
        r_req <= n_req;
        r_id <= n_id;
        r_cpu <= n_cpu;
        r_mem <= n_mem;
        r_idx <= n_idx;
        r_pidx <= n_pidx;
        r_hit <= n_hit;
        r_best <= n_best;
        r_best_id <= n_best_id;
        r_slot <= n_slot;
        r_k <= n_k;
        r_acc_c <= n_acc_c;
        r_acc_m <= n_acc_m;
        r_sum_c <= n_sum_c;
        r_sum_m <= n_sum_m;
        r_st <= n_st;
        r_cid <= n_cid;
        r_pr <= n_pr;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

    eps_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_PROCS),
        .AW   (IW)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (e_we),
        .i_waddr(e_waddr),
        .i_wdata(e_wdata),
        .i_raddr(r_idx[IW-1:0]),
        .o_rdata(e_rdata)
    );

    eps_ram #(
        .WIDTH(2 * SB),
        .DEPTH(WD),
        .AW   (WAW)
    ) u_window_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("entry count above table size");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("entry count moved by other than one");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eps_pkg::S_SCAN) |-> (!e_we && !w_we))
        else $error("table written during scan");

    a_empty_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ouser == eps_pkg::ST_EMPTY) |-> (r_odata[31:0] == '0))
        else $error("empty pick returned an id");

endmodule
